// ===== rtl/sts_pkg.sv =====
// Shared constants, kind codes and types of the sorted table search-insert block.
`timescale 1ns / 1ps
package sts_pkg;

    localparam int DEPTH     = 256;
    localparam int KEY_WIDTH = 32;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = ADDR_W + 1;

    localparam int KIND_W  = 2;
    localparam int INDEX_W = 8;
    localparam int POS_W   = 8;
    localparam int VAL_W   = 32;
    localparam int COUNT_W = 9;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 56;

    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd3;

    typedef struct packed {
        logic                 we;
        logic [ADDR_W-1:0]    waddr;
        logic [KEY_WIDTH-1:0] wdata;
        logic                 re;
        logic [ADDR_W-1:0]    raddr;
    } mem_req_t;

endpackage

// ===== rtl/sts_mem.sv =====
// Entry store of the sorted table: one write port and one registered read port.
`timescale 1ns / 1ps
module sts_mem
    import sts_pkg::*;
(
    input  logic                 clk,
    input  mem_req_t             req,
    output logic [KEY_WIDTH-1:0] rd_data
);

    logic [KEY_WIDTH-1:0] mem [DEPTH];
    logic [KEY_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/sorted_table_search_insert.sv =====
// Search-insert: an accept step, then binary-search probes, each a memory read (PROBE) and a
// compare (CMP), one closing probe, then shift steps through the single memory port pair,
// one write step and one output step; a found key or a full table goes straight to output.
// Load works alike; read issues its memory read on accept, clear goes straight to output.
// One request is in work at a time; a finished result waits in the output register.
// Reset clears the fill count and all control; entries are undefined until written.
`timescale 1ns / 1ps
module sorted_table_search_insert
    import sts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // key[31:0], index[39:32]
    input  logic [KIND_W-1:0]     s_tuser,   // kind[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // found[0], position[8:1], inserted[9],
                                             // full_res[10], entry_value[42:11],
                                             // count[51:43], zero[55:52]
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PROBE = 7'b0000010,
        ST_CMP   = 7'b0000100,
        ST_SHIFT = 7'b0001000,
        ST_WRITE = 7'b0010000,
        ST_RDATA = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     lo_reg, lo_next;
    logic [CNT_W-1:0]     hi_reg, hi_next;
    logic [CNT_W-1:0]     mid_reg, mid_next;
    logic [CNT_W-1:0]     sh_reg, sh_next;
    logic [ADDR_W-1:0]    wa_reg, wa_next;
    logic                 pend_reg, pend_next;
    logic                 srch_reg, srch_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;

    logic                 found_reg, found_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic                 ins_reg, ins_next;
    logic                 full_reg, full_next;
    logic [VAL_W-1:0]     val_reg, val_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    mem_req_t             req;
    logic [KEY_WIDTH-1:0] rd_data;

    logic                 accept;
    logic [CNT_W-1:0]     span;
    logic [CNT_W-1:0]     mid;
    logic [CNT_W-1:0]     sh_m1;
    logic                 key_lt;
    logic                 key_eq;

    sts_mem u_mem (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Search uses the floor of (r - l) / 2 with r = hi - 1; load uses (hi - lo) / 2.
    assign span   = hi_reg - lo_reg - {{(CNT_W-1){1'b0}}, srch_reg};
    assign mid    = lo_reg + (span >> 1);
    assign sh_m1  = sh_reg - {{(CNT_W-1){1'b0}}, 1'b1};
    assign key_lt = $signed(rd_data) < $signed(key_reg);
    assign key_eq = (rd_data == key_reg);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        sh_next       = sh_reg;
        wa_next       = wa_reg;
        pend_next     = pend_reg;
        srch_next     = srch_reg;
        key_next      = key_reg;
        found_next    = found_reg;
        pos_next      = pos_reg;
        ins_next      = ins_reg;
        full_next     = full_reg;
        val_next      = val_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        req           = '0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    key_next   = s_tdata[KEY_WIDTH-1:0];
                    srch_next  = (s_tuser == KIND_SEARCH);
                    found_next = 1'b0;
                    pos_next   = '0;
                    ins_next   = 1'b0;
                    full_next  = 1'b0;
                    val_next   = '0;
                    lo_next    = '0;
                    hi_next    = count_reg;
                    unique case (s_tuser)
                        KIND_SEARCH:
                        begin
                            state_next = ST_PROBE;
                        end
                        KIND_LOAD:
                        begin
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                full_next  = 1'b1;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_PROBE;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            count_next = '0;
                            state_next = ST_DONE;
                        end
                        KIND_READ:
                        begin
                            pos_next   = s_tdata[KEY_WIDTH +: INDEX_W];
                            req.re     = 1'b1;
                            req.raddr  = s_tdata[KEY_WIDTH +: ADDR_W];
                            state_next = ST_RDATA;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_PROBE:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid;
                    req.re     = 1'b1;
                    req.raddr  = mid[ADDR_W-1:0];
                    state_next = ST_CMP;
                end
                else if (srch_reg && (count_reg == CNT_W'(DEPTH)))
                begin
                    full_next  = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    pos_next   = lo_reg[POS_W-1:0];
                    ins_next   = 1'b1;
                    sh_next    = count_reg;
                    pend_next  = 1'b0;
                    state_next = ST_SHIFT;
                end
            end

            ST_CMP:
            begin
                priority if (srch_reg && key_eq)
                begin
                    found_next = 1'b1;
                    pos_next   = mid_reg[POS_W-1:0];
                    state_next = ST_DONE;
                end
                else if (key_lt)
                begin
                    lo_next    = mid_reg + {{(CNT_W-1){1'b0}}, 1'b1};
                    state_next = ST_PROBE;
                end
                else
                begin
                    hi_next    = mid_reg;
                    state_next = ST_PROBE;
                end
            end

            ST_SHIFT:
            begin
                // Read entry sh-1 now, write it one place up on the next cycle.
                req.we    = pend_reg;
                req.waddr = wa_reg;
                req.wdata = rd_data;
                if (sh_reg > {1'b0, pos_reg})
                begin
                    req.re    = 1'b1;
                    req.raddr = sh_m1[ADDR_W-1:0];
                    pend_next = 1'b1;
                    wa_next   = sh_reg[ADDR_W-1:0];
                    sh_next   = sh_m1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = ST_WRITE;
                end
            end

            ST_WRITE:
            begin
                req.we     = 1'b1;
                req.waddr  = pos_reg[ADDR_W-1:0];
                req.wdata  = key_reg;
                count_next = count_reg + {{(CNT_W-1){1'b0}}, 1'b1};
                state_next = ST_DONE;
            end

            ST_RDATA:
            begin
                if ({1'b0, pos_reg} < count_reg)
                begin
                    found_next = 1'b1;
                    val_next   = rd_data;
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'd0, count_reg, val_reg, full_reg, ins_reg,
                                     pos_reg, found_reg};
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        sh_reg      <= sh_next;
        wa_reg      <= wa_next;
        srch_reg    <= srch_next;
        key_reg     <= key_next;
        found_reg   <= found_next;
        pos_reg     <= pos_next;
        ins_reg     <= ins_next;
        full_reg    <= full_next;
        val_reg     <= val_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

// ===== rtl/sts_chk.sv =====
// Port-level checker of the sorted table search-insert block, bound to the top level.
`timescale 1ns / 1ps
module sts_chk
    import sts_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [IN_DATA_W-1:0]  s_tdata,
    input logic [KIND_W-1:0]     s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    logic                 res_found;
    logic [POS_W-1:0]     res_pos;
    logic                 res_ins;
    logic                 res_full;
    logic [COUNT_W-1:0]   res_count;

    assign res_found = m_tdata[0];
    assign res_pos   = m_tdata[8:1];
    assign res_ins   = m_tdata[9];
    assign res_full  = m_tdata[10];
    assign res_count = m_tdata[51:43];

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> res_count <= COUNT_W'(DEPTH))
        else $error("count beyond table depth");

    // A request ends in at most one of found, inserted and refused.
    a_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(res_ins && res_full) && !(res_ins && res_found)
                     && !(res_found && res_full))
        else $error("conflicting outcome flags");

    // An inserted key sits inside the filled part of the table.
    a_ins_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res_ins |-> ({1'b0, res_pos} < res_count))
        else $error("insert position outside the table");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res_full |-> res_count == COUNT_W'(DEPTH) && res_pos == '0)
        else $error("refused insert while table not full");

endmodule

bind sorted_table_search_insert sts_chk u_sts_chk (.*);

// ===== verif/tb_sorted_table_search_insert.sv =====
// Self-checking testbench for the sorted table search-insert block.
`timescale 1ns / 1ps
module tb_sorted_table_search_insert;
    import sts_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 300;

    typedef struct packed {
        logic                 found;
        logic [POS_W-1:0]     position;
        logic                 inserted;
        logic                 full_res;
        logic [VAL_W-1:0]     entry_value;
        logic [COUNT_W-1:0]   count;
    } table_result_t;

    typedef struct {
        logic [KIND_W-1:0]    kind;
        logic [KEY_WIDTH-1:0] key;
        logic [INDEX_W-1:0]   index;
        bit                   typed;
        table_result_t        want;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [KIND_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    // Shadow copy of the table contents and its fill level.
    logic signed [KEY_WIDTH-1:0] key_table [DEPTH];
    int                          fill_level;

    table_result_t owed_results [$];
    stim_row_t     directed_rows [$];
    table_result_t head;
    int            mismatches   = 0;
    int            results_seen = 0;
    int            idle_cycles  = 0;
    bit            no_idle;
    bit            hold_done    = 1'b0;

    sorted_table_search_insert dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one request to the shadow table and returns the result it must produce.
    function automatic table_result_t search_insert_step(input logic [KIND_W-1:0] kind,
                                                         input logic signed [KEY_WIDTH-1:0] key,
                                                         input logic [INDEX_W-1:0] index);
        table_result_t r;
        int            lo;
        int            hi;
        int            mid;
        int            i;
        bit            hit;
        r   = '0;
        hit = 1'b0;
        case (kind)
            KIND_SEARCH:
            begin
                lo = 0;
                hi = fill_level - 1;
                while (lo <= hi && !hit)
                begin
                    mid = lo + (hi - lo) / 2;
                    if (key_table[mid] == key)
                    begin
                        hit        = 1'b1;
                        r.found    = 1'b1;
                        r.position = POS_W'(mid);
                    end
                    else if (key_table[mid] < key)
                        lo = mid + 1;
                    else
                        hi = mid - 1;
                end
                if (!hit)
                begin
                    if (fill_level >= DEPTH)
                        r.full_res = 1'b1;
                    else
                    begin
                        for (i = fill_level; i > lo; i--)
                            key_table[i] = key_table[i-1];
                        key_table[lo] = key;
                        fill_level++;
                        r.position = POS_W'(lo);
                        r.inserted = 1'b1;
                    end
                end
            end
            KIND_LOAD:
            begin
                if (fill_level >= DEPTH)
                    r.full_res = 1'b1;
                else
                begin
                    // A load goes in front of any equal keys.
                    lo = 0;
                    hi = fill_level;
                    while (lo < hi)
                    begin
                        mid = lo + (hi - lo) / 2;
                        if (key_table[mid] < key)
                            lo = mid + 1;
                        else
                            hi = mid;
                    end
                    for (i = fill_level; i > lo; i--)
                        key_table[i] = key_table[i-1];
                    key_table[lo] = key;
                    fill_level++;
                    r.position = POS_W'(lo);
                    r.inserted = 1'b1;
                end
            end
            KIND_CLEAR:
                fill_level = 0;
            default:
            begin
                r.position = index;
                if (int'(index) < fill_level)
                begin
                    r.found       = 1'b1;
                    r.entry_value = key_table[index];
                end
            end
        endcase
        r.count = COUNT_W'(fill_level);
        return r;
    endfunction

    // Keys are drawn so that matches, duplicates and extremes show up often.
    function automatic logic [KEY_WIDTH-1:0] pick_key();
        int near;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1:
            begin
                near = $urandom_range(0, 40);
                return near - 20;
            end
            2:
            begin
                if (fill_level > 0)
                    return key_table[$urandom_range(0, fill_level - 1)];
                return $urandom;
            end
            default:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h8000_0001;
                    default: return 32'h7FFF_FFFE;
                endcase
            end
        endcase
    endfunction

    task automatic add_row(input logic [KIND_W-1:0] kind, input logic [KEY_WIDTH-1:0] key,
                           input logic [INDEX_W-1:0] index, input bit typed,
                           input logic f, input logic [POS_W-1:0] p, input logic ins,
                           input logic full, input logic [VAL_W-1:0] v,
                           input logic [COUNT_W-1:0] c);
        stim_row_t row;
        row.kind  = kind;
        row.key   = key;
        row.index = index;
        row.typed = typed;
        row.want  = '{found: f, position: p, inserted: ins, full_res: full,
                      entry_value: v, count: c};
        directed_rows = {directed_rows, row};
    endtask

    // Offers one request, waits for it to be taken and records the result it owes.
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [KEY_WIDTH-1:0] key,
                                input logic [INDEX_W-1:0] index, input bit typed,
                                input table_result_t want);
        table_result_t predicted;
        int            gap;
        if (!no_idle && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 14);
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = {index, key};
        s_tuser  = kind;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = search_insert_step(kind, key, index);
        owed_results = {owed_results, (typed ? want : predicted)};
    endtask

    task automatic send_random(input logic [KIND_W-1:0] kind, input int read_max);
        send_request(kind, pick_key(), INDEX_W'($urandom_range(0, read_max)), 1'b0, '0);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (owed_results.size() == 0)
            begin
                $error("result 0x%0h arrived with none outstanding", m_tdata);
                mismatches++;
            end
            else
            begin
                head = owed_results.pop_front();
                check_field("found", 32'(head.found), 32'(m_tdata[0]));
                check_field("position", 32'(head.position), 32'(m_tdata[8:1]));
                check_field("inserted", 32'(head.inserted), 32'(m_tdata[9]));
                check_field("full_res", 32'(head.full_res), 32'(m_tdata[10]));
                check_field("entry_value", head.entry_value, m_tdata[42:11]);
                check_field("count", 32'(head.count), 32'(m_tdata[51:43]));
                check_field("pad", 32'd0, 32'(m_tdata[55:52]));
            end
        end
    end

    // Result side: random stall bursts plus one long hold that backs up the input.
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!hold_done && results_seen >= 40)
            begin
                hold_done = 1'b1;
                m_tready  = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (!no_idle && $urandom_range(0, 5) == 0)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 14) - 1) @(negedge clk);
            end
            else
                m_tready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        int k;
        int r;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = KIND_SEARCH;
        no_idle      = 1'b0;
        fill_level   = 0;

        //      kind         key            index  typed fnd pos ins full value         cnt
        add_row(KIND_READ,   32'h0000_0000, 8'd0,   1, 0, 8'd0,   0, 0, 32'd0,         9'd0);
        add_row(KIND_READ,   32'hFFFF_FFFF, 8'd255, 1, 0, 8'd255, 0, 0, 32'd0,         9'd0);
        add_row(KIND_SEARCH, 32'h0000_0000, 8'hFF,  1, 0, 8'd0,   1, 0, 32'd0,         9'd1);
        add_row(KIND_SEARCH, 32'h8000_0000, 8'd0,   1, 0, 8'd0,   1, 0, 32'd0,         9'd2);
        add_row(KIND_SEARCH, 32'h7FFF_FFFF, 8'd0,   1, 0, 8'd2,   1, 0, 32'd0,         9'd3);
        add_row(KIND_SEARCH, 32'hFFFF_FFFF, 8'd0,   1, 0, 8'd1,   1, 0, 32'd0,         9'd4);
        add_row(KIND_SEARCH, 32'h0000_0000, 8'd0,   1, 1, 8'd2,   0, 0, 32'd0,         9'd4);
        add_row(KIND_LOAD,   32'h0000_0000, 8'd0,   1, 0, 8'd2,   1, 0, 32'd0,         9'd5);
        add_row(KIND_LOAD,   32'h8000_0000, 8'd0,   1, 0, 8'd0,   1, 0, 32'd0,         9'd6);
        add_row(KIND_LOAD,   32'h7FFF_FFFF, 8'd0,   1, 0, 8'd5,   1, 0, 32'd0,         9'd7);
        add_row(KIND_SEARCH, 32'h7FFF_FFFF, 8'd0,   0, 0, 8'd0,   0, 0, 32'd0,         9'd0);
        add_row(KIND_READ,   32'h1234_5678, 8'd0,   1, 1, 8'd0,   0, 0, 32'h8000_0000, 9'd7);
        add_row(KIND_READ,   32'h0000_0000, 8'd6,   1, 1, 8'd6,   0, 0, 32'h7FFF_FFFF, 9'd7);
        add_row(KIND_READ,   32'h0000_0000, 8'd7,   1, 0, 8'd7,   0, 0, 32'd0,         9'd7);
        add_row(KIND_SEARCH, 32'd12345,     8'd0,   0, 0, 8'd0,   0, 0, 32'd0,         9'd0);
        add_row(KIND_LOAD,   32'hFFFF_FFFF, 8'd0,   0, 0, 8'd0,   0, 0, 32'd0,         9'd0);
        add_row(KIND_READ,   32'h0000_0000, 8'd3,   0, 0, 8'd0,   0, 0, 32'd0,         9'd0);
        add_row(KIND_SEARCH, 32'h5555_5555, 8'hAA,  0, 0, 8'd0,   0, 0, 32'd0,         9'd0);
        add_row(KIND_SEARCH, 32'hAAAA_AAAA, 8'h55,  0, 0, 8'd0,   0, 0, 32'd0,         9'd0);
        add_row(KIND_CLEAR,  32'hFFFF_FFFF, 8'hFF,  1, 0, 8'd0,   0, 0, 32'd0,         9'd0);
        add_row(KIND_READ,   32'h0000_0000, 8'd0,   1, 0, 8'd0,   0, 0, 32'd0,         9'd0);
        add_row(KIND_LOAD,   32'd5,         8'd0,   1, 0, 8'd0,   1, 0, 32'd0,         9'd1);
        add_row(KIND_SEARCH, 32'd5,         8'd0,   1, 1, 8'd0,   0, 0, 32'd0,         9'd1);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].kind, directed_rows[i].key, directed_rows[i].index,
                         directed_rows[i].typed, directed_rows[i].want);

        // Mixed traffic on a small table.
        repeat (50)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                send_random(KIND_SEARCH, 255);
            else if (r < 70)
                send_random(KIND_LOAD, 255);
            else if (r < 95)
                send_random(KIND_READ, fill_level);
            else
                send_random(KIND_CLEAR, 255);
        end

        // Fill the table to capacity, then exercise every kind against a full table.
        send_random(KIND_CLEAR, 255);
        while (fill_level < DEPTH)
        begin
            r = $urandom_range(0, 9);
            if (r < 2)
                send_random(KIND_SEARCH, 255);
            else if (r < 9)
                send_random(KIND_LOAD, 255);
            else
                send_random(KIND_READ, fill_level);
        end
        repeat (24)
        begin
            k = $urandom_range(0, 3);
            if (k == 0)
                send_request(KIND_SEARCH, key_table[$urandom_range(0, DEPTH - 1)],
                             INDEX_W'($urandom), 1'b0, '0);
            else if (k == 1)
                send_random(KIND_SEARCH, 255);
            else if (k == 2)
                send_random(KIND_LOAD, 255);
            else
                send_random(KIND_READ, 255);
        end
        send_request(KIND_READ, $urandom, 8'd255, 1'b0, '0);
        send_random(KIND_CLEAR, 255);

        // Closing stretch at full rate on both sides.
        no_idle = 1'b1;
        repeat (30)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                send_random(KIND_SEARCH, 255);
            else if (r < 70)
                send_random(KIND_LOAD, 255);
            else if (r < 95)
                send_random(KIND_READ, fill_level);
            else
                send_random(KIND_CLEAR, 255);
        end
        @(negedge clk);
        s_tvalid = 1'b0;

        wait (owed_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
